FILE: design/longest_increasing_grid_path_macros.svh
// ----------------------------------------------------------------------------
// Longest increasing grid path: assertion macros
// Shared concurrent assertion forms, clocked on clk with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef LONGEST_INCREASING_GRID_PATH_MACROS_SVH
`define LONGEST_INCREASING_GRID_PATH_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define LIGP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define LIGP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: design/ligp_pkg.sv
// ----------------------------------------------------------------------------
// ligp_pkg
// Types and constants shared by the longest increasing grid path modules.
// ----------------------------------------------------------------------------
package ligp_pkg;

  // Width of a path length, and its saturation value.
  localparam int LEN_W = 13;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // Width of a grid dimension register.
  localparam int DIM_W = 7;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  // Sweep engine states.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLEAR = 5'b00010,
    ST_SWEEP = 5'b00100,
    ST_DONE  = 5'b01000,
    ST_SPARE = 5'b10000
  } eng_state_t;

  // Status of the sweep engine seen by the top level.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [LEN_W-1:0] best;
  } eng_stat_t;

endpackage

FILE: design/ligp_ram.sv
// ----------------------------------------------------------------------------
// ligp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ligp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/ligp_engine.sv
// ----------------------------------------------------------------------------
// ligp_engine
// Relaxation sweep sequencer: clears the length store, then sweeps the grid
// one cell at a time until a whole sweep changes nothing.
// ----------------------------------------------------------------------------
`include "longest_increasing_grid_path_macros.svh"

module ligp_engine #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLS    = 64,
  parameter int VALUE_WIDTH = 32,
  localparam int CAP = MAX_ROWS * MAX_COLS,
  localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                go,
  input  logic [ligp_pkg::DIM_W-1:0]          rows,
  input  logic [ligp_pkg::DIM_W-1:0]          cols,
  output logic [AW-1:0]                       val_raddr,
  input  logic signed [VALUE_WIDTH-1:0]       val_rdata,
  output ligp_pkg::eng_stat_t                 stat
);

  localparam int LW = ligp_pkg::LEN_W;
  localparam int DW = ligp_pkg::DIM_W;

  ligp_pkg::eng_state_t state_r, state_nxt;
  logic [2:0]    step_r, step_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [DW-1:0] row_r, row_nxt, col_r, col_nxt;
  logic          vld_r, changed_r, changed_nxt;
  logic [LW-1:0] best_r, best_nxt, acc_r, acc_nxt, hl_r, hl_nxt;
  logic signed [VALUE_WIDTH-1:0] hv_r, hv_nxt;

  logic [2*DW-1:0] total;
  logic            last_idx;
  logic [AW-1:0]   addr;
  logic            nvalid;
  logic [LW-1:0]   l_rdata, inc, len_nxt;
  logic            len_we;
  logic [LW-1:0]   len_wdata;

  assign total    = rows * cols;
  assign last_idx = (32'(idx_r) == 32'(total) - 32'd1);

  // Address of the item read in this step: the cell, then its four neighbours.
  always_comb begin
    addr   = idx_r;
    nvalid = 1'b0;
    unique case (step_r)
      3'd1: begin
        addr   = idx_r - AW'(cols);
        nvalid = (row_r != '0);
      end
      3'd2: begin
        addr   = idx_r + AW'(1);
        nvalid = (col_r + DW'(1) < cols);
      end
      3'd3: begin
        addr   = idx_r + AW'(cols);
        nvalid = (row_r + DW'(1) < rows);
      end
      3'd4: begin
        addr   = idx_r - AW'(1);
        nvalid = (col_r != '0);
      end
      default: begin
        addr   = idx_r;
        nvalid = 1'b0;
      end
    endcase
  end

  assign val_raddr = addr;

  // Relaxation of one neighbour against the running length of the cell.
  assign inc     = (l_rdata == ligp_pkg::LEN_MAX) ? l_rdata : l_rdata + LW'(1);
  assign len_nxt = (vld_r && (val_rdata > hv_r) && (inc > acc_r)) ? inc : acc_r;

  // Length store write: ones while clearing, the relaxed length at step five.
  always_comb begin
    len_we    = (state_r == ligp_pkg::ST_CLEAR) ||
                (state_r == ligp_pkg::ST_SWEEP && step_r == 3'd5);
    len_wdata = (state_r == ligp_pkg::ST_CLEAR) ? LW'(1) : len_nxt;
  end

  ligp_ram #(.WIDTH(LW), .DEPTH(CAP)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (idx_r),
    .wdata (len_wdata),
    .raddr (addr),
    .rdata (l_rdata)
  );

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    idx_nxt     = idx_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    changed_nxt = changed_r;
    best_nxt    = best_r;
    acc_nxt     = acc_r;
    hl_nxt      = hl_r;
    hv_nxt      = hv_r;
    unique case (state_r)
      ligp_pkg::ST_IDLE: begin
        if (go) begin
          state_nxt = ligp_pkg::ST_CLEAR;
          idx_nxt   = '0;
        end
      end
      ligp_pkg::ST_CLEAR: begin
        idx_nxt = idx_r + AW'(1);
        if (last_idx) begin
          state_nxt   = ligp_pkg::ST_SWEEP;
          idx_nxt     = '0;
          row_nxt     = '0;
          col_nxt     = '0;
          step_nxt    = '0;
          changed_nxt = 1'b0;
          best_nxt    = '0;
        end
      end
      ligp_pkg::ST_SWEEP: begin
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd1) begin
          hv_nxt  = val_rdata;
          acc_nxt = l_rdata;
          hl_nxt  = l_rdata;
        end else if (step_r >= 3'd2 && step_r <= 3'd4) begin
          acc_nxt = len_nxt;
        end else if (step_r == 3'd5) begin
          step_nxt    = '0;
          changed_nxt = changed_r || (len_nxt != hl_r);
          best_nxt    = (len_nxt > best_r) ? len_nxt : best_r;
          idx_nxt     = idx_r + AW'(1);
          if (col_r + DW'(1) == cols) begin
            col_nxt = '0;
            row_nxt = row_r + DW'(1);
          end else begin
            col_nxt = col_r + DW'(1);
          end
          if (last_idx) begin
            idx_nxt = '0;
            row_nxt = '0;
            col_nxt = '0;
            if (changed_nxt) begin
              changed_nxt = 1'b0;
              best_nxt    = '0;
            end else begin
              state_nxt = ligp_pkg::ST_DONE;
            end
          end
        end
      end
      ligp_pkg::ST_DONE: begin
        state_nxt = ligp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = ligp_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ligp_pkg::ST_IDLE;
      step_r    <= '0;
      changed_r <= 1'b0;
      vld_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      changed_r <= changed_nxt;
      vld_r     <= nvalid;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    best_r <= best_nxt;
    acc_r  <= acc_nxt;
    hl_r   <= hl_nxt;
    hv_r   <= hv_nxt;
  end

  assign stat.busy = (state_r != ligp_pkg::ST_IDLE);
  assign stat.done = (state_r == ligp_pkg::ST_DONE);
  assign stat.best = best_r;

  // Checks on the sequencer.
  `LIGP_ASSERT(a_len_we_when, len_we |-> (state_r == ligp_pkg::ST_CLEAR) || (step_r == 3'd5), "length write outside clear or step five")
  `LIGP_NEVER(a_step_range, step_r > 3'd5, "sweep step out of range")
  `LIGP_ASSERT(a_done_idle, (state_r == ligp_pkg::ST_DONE) |=> (state_r == ligp_pkg::ST_IDLE), "done not followed by idle")
  `LIGP_ASSERT(a_go_clear, (go && state_r == ligp_pkg::ST_IDLE) |=> (state_r == ligp_pkg::ST_CLEAR), "go did not start clearing")

endmodule

FILE: design/longest_increasing_grid_path.sv
// ----------------------------------------------------------------------------
// longest_increasing_grid_path
// Loads a grid and reports its longest strictly increasing neighbour path.
// ----------------------------------------------------------------------------
// Cells load one per cycle while busy is low; each is written to the value
// memory as it arrives. The cell marked last starts the computation when the
// cell count equals rows times columns: busy then rises, the length memory is
// cleared, and relaxation sweeps follow cell by cell (one read of the cell and
// its four neighbours through the memories' single read port, then a write
// back), repeated until a sweep changes nothing.
// The result appears with out_valid for one cycle and cannot be stalled; a
// count or dimension error gives its result the cycle after the last cell.
// ----------------------------------------------------------------------------
module longest_increasing_grid_path #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLS    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [31:0]                  in_cell_value,
  input  logic                                in_last_cell,
  output logic                                out_valid,
  output logic [ligp_pkg::LEN_W-1:0]          out_path_length,
  output logic                                out_count_error,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ligp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ligp_pkg::DIM_W-1:0]          cfg_data
);

  localparam int CAP  = MAX_ROWS * MAX_COLS;
  localparam int AW   = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int CNTW = $clog2(CAP + 2);
  localparam int KEEP = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

  logic [ligp_pkg::DIM_W-1:0] rows_r, cols_r;
  logic [CNTW-1:0]            cnt_r, cnt_nxt;
  logic                       accept, ok, go;
  logic signed [VALUE_WIDTH-1:0] value_in;
  logic [AW-1:0]              val_raddr;
  logic signed [VALUE_WIDTH-1:0] val_rdata;
  ligp_pkg::eng_stat_t        stat;
  logic                       out_valid_r;
  logic [ligp_pkg::LEN_W-1:0] len_r;
  logic                       err_r;

  assign accept    = start && !busy;
  assign busy      = stat.busy;
  assign cfg_ready = 1'b1;

  // Keep the low bits of the value and sign-extend them to the store width.
  generate
    if (VALUE_WIDTH >= 32) begin : g_wide
      assign value_in = VALUE_WIDTH'(in_cell_value);
    end else begin : g_narrow
      assign value_in = in_cell_value[KEEP-1:0];
    end
  endgenerate

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ligp_pkg::DIM_W'(64);
      cols_r <= ligp_pkg::DIM_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ligp_pkg::REG_ROWS: rows_r <= cfg_data;
        ligp_pkg::REG_COLS: cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Load count saturates one above the capacity.
  assign cnt_nxt = (32'(cnt_r) <= CAP) ? cnt_r + CNTW'(1) : cnt_r;
  assign ok = (rows_r != '0) && (32'(rows_r) <= MAX_ROWS) &&
              (cols_r != '0) && (32'(cols_r) <= MAX_COLS) &&
              (32'(cnt_nxt) == 32'(rows_r) * 32'(cols_r));
  assign go = accept && in_last_cell && ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      cnt_r <= in_last_cell ? '0 : cnt_nxt;
    end
  end

  ligp_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAP)) u_val_ram (
    .clk   (clk),
    .we    (accept && (32'(cnt_r) < CAP)),
    .waddr (AW'(cnt_r)),
    .wdata (value_in),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  ligp_engine #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .rows      (rows_r),
    .cols      (cols_r),
    .val_raddr (val_raddr),
    .val_rdata (val_rdata),
    .stat      (stat)
  );

  // Result transaction: engine completion or an immediate error.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= stat.done || (accept && in_last_cell && !ok);
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      len_r <= stat.best;
      err_r <= 1'b0;
    end else begin
      len_r <= '0;
      err_r <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_path_length = len_r;
  assign out_count_error = err_r;

endmodule
